>>> src/evpsc_pkg.sv
// Package: types, codes and the per-tick state update helpers of the EV power state controller.
package evpsc_pkg;

  localparam int TIMER_BITS  = 16;
  localparam int DELAY_BITS  = 16;
  localparam int TIMER_CMP_W = (TIMER_BITS > DELAY_BITS) ? TIMER_BITS : DELAY_BITS;

  localparam int IN_W   = 56;
  localparam int OUT_W  = 24;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  typedef enum logic [1:0] {
    MODE_STANDBY  = 2'd0,
    MODE_RUN      = 2'd1,
    MODE_CHARGING = 2'd2
  } evpsc_mode_t;

  typedef enum logic [1:0] {
    DC_UNSET = 2'd0,
    DC_BOOST = 2'd1,
    DC_BUCK  = 2'd2
  } evpsc_dcdc_t;

  typedef enum logic [1:0] {
    DEM_STANDBY = 2'd0,
    DEM_SLEEP   = 2'd1,
    DEM_CHARGE  = 2'd2
  } evpsc_demand_t;

  localparam logic [2:0] LED_OFF      = 3'd0;
  localparam logic [2:0] LED_STANDBY  = 3'd1;
  localparam logic [2:0] LED_READY    = 3'd3;
  localparam logic [2:0] LED_CHARGING = 3'd4;

  localparam logic [2:0] CST_SLEEP    = 3'd0;
  localparam logic [2:0] CST_STANDBY  = 3'd1;
  localparam logic [2:0] CST_READY    = 3'd2;
  localparam logic [2:0] CST_CHARGING = 3'd3;

  localparam logic [CFG_IW-1:0] CFG_MODE_CHANGE_DELAY    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PRECHARGE_WINDOW     = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_PRECHARGE_MIN_VOLTS  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INVERTER_TEMP_HIGH   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_INVERTER_TEMP_LOW    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_MOTOR_TEMP_HIGH      = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_MOTOR_TEMP_LOW       = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_COOLING_REQUEST_HIGH = 3'd7;

  typedef struct packed {
    logic [DELAY_BITS-1:0] mode_change_delay;
    logic [7:0]            precharge_window;
    logic [9:0]            precharge_min_volts;
    logic signed [7:0]     inverter_temp_high;
    logic signed [7:0]     inverter_temp_low;
    logic signed [7:0]     motor_temp_high;
    logic signed [7:0]     motor_temp_low;
    logic signed [7:0]     cooling_request_high;
  } evpsc_cfg_t;

  localparam evpsc_cfg_t CFG_RESET = '{
    mode_change_delay:    16'd500,
    precharge_window:     8'd20,
    precharge_min_volts:  10'd50,
    inverter_temp_high:   8'sd60,
    inverter_temp_low:    8'sd50,
    motor_temp_high:      8'sd80,
    motor_temp_low:       8'sd70,
    cooling_request_high: 8'sd50
  };

  typedef struct packed {
    logic              ignition;
    logic              charger_wake;
    logic [9:0]        battery_volts;
    logic [9:0]        bus_volts;
    logic signed [7:0] inverter_temp;
    logic signed [7:0] motor_temp;
    logic signed [7:0] cooling_request;
    logic              reverse_gear;
    logic [2:0]        charger_status;
    logic              plug_locked;
    logic              unlock_event;
  } evpsc_in_t;

  typedef struct packed {
    evpsc_mode_t           mode;
    logic                  armed;
    logic                  precharge_done;
    logic                  charge_finished;
    logic                  unlock_sticky;
    logic                  unlock_pending;
    logic                  unlock_req;
    evpsc_dcdc_t           dcdc_mode;
    logic [TIMER_BITS-1:0] mode_timer;
    logic                  wake_motor;
    logic                  wake_dcdc;
    logic                  wake_charger;
    logic                  contactor;
    logic                  pump;
    logic                  reverse;
    logic                  dcdc_en;
    evpsc_demand_t         demand;
    logic [2:0]            led;
  } evpsc_state_t;

  localparam evpsc_state_t ST_RESET = '{
    mode:            MODE_STANDBY,
    armed:           1'b0,
    precharge_done:  1'b0,
    charge_finished: 1'b0,
    unlock_sticky:   1'b0,
    unlock_pending:  1'b0,
    unlock_req:      1'b0,
    dcdc_mode:       DC_UNSET,
    mode_timer:      '0,
    wake_motor:      1'b0,
    wake_dcdc:       1'b0,
    wake_charger:    1'b0,
    contactor:       1'b0,
    pump:            1'b0,
    reverse:         1'b0,
    dcdc_en:         1'b0,
    demand:          DEM_STANDBY,
    led:             LED_OFF
  };

  typedef struct packed {
    evpsc_mode_t   vehicle_mode;
    logic [2:0]    wake_lines;
    logic          contactor_closed;
    logic          pump_on;
    logic          reverse_light;
    logic          dcdc_enable;
    logic          dcdc_boost;
    evpsc_demand_t charger_demand;
    logic [2:0]    charge_led;
    logic          unlock_request;
    logic          sleep_request;
  } evpsc_res_t;

  function automatic evpsc_state_t st_disarm(evpsc_state_t s);
    evpsc_state_t r;
    r                = s;
    r.armed          = 1'b0;
    r.dcdc_en        = 1'b0;
    r.precharge_done = 1'b0;
    r.contactor      = 1'b0;
    return r;
  endfunction

  function automatic evpsc_state_t st_to_standby(evpsc_state_t s);
    evpsc_state_t r;
    r                 = s;
    r.mode            = MODE_STANDBY;
    r.charge_finished = 1'b0;
    r                 = st_disarm(r);
    return r;
  endfunction

  function automatic evpsc_state_t st_set_dcdc(evpsc_state_t s, evpsc_dcdc_t m);
    evpsc_state_t r;
    r = s;
    if (r.dcdc_mode != m) begin
      r.dcdc_mode  = m;
      r.mode_timer = '0;
      r.dcdc_en    = 1'b0;
    end
    return r;
  endfunction

  function automatic evpsc_state_t st_arm_battery(evpsc_state_t s, evpsc_cfg_t c,
                                                  logic [9:0] batt, logic [9:0] bus);
    evpsc_state_t      r;
    logic signed [11:0] lo;
    logic signed [11:0] hi;
    logic signed [11:0] bus_s;
    logic               waited;
    r     = s;
    lo    = $signed({2'b00, batt}) - $signed({4'b0000, c.precharge_window});
    hi    = $signed({2'b00, batt}) + $signed({4'b0000, c.precharge_window});
    bus_s = $signed({2'b00, bus});
    if (!r.precharge_done) begin
      r      = st_set_dcdc(r, DC_BOOST);
      waited = TIMER_CMP_W'(r.mode_timer) >= TIMER_CMP_W'(c.mode_change_delay);
      if (waited) begin
        r.dcdc_en = 1'b1;
        if (bus_s >= lo && bus_s <= hi && bus > c.precharge_min_volts) begin
          r.precharge_done = 1'b1;
          r.contactor      = 1'b1;
          r.dcdc_en        = 1'b0;
        end
      end
    end else begin
      r.armed = 1'b1;
      r       = st_set_dcdc(r, DC_BUCK);
      waited  = TIMER_CMP_W'(r.mode_timer) >= TIMER_CMP_W'(c.mode_change_delay);
      if (waited) begin
        r.dcdc_en = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic evpsc_state_t st_cooling(evpsc_state_t s, evpsc_cfg_t c, evpsc_in_t i);
    evpsc_state_t r;
    r = s;
    if (r.armed) begin
      if (i.inverter_temp > c.inverter_temp_high || i.motor_temp > c.motor_temp_high ||
          i.cooling_request > c.cooling_request_high) begin
        r.pump = 1'b1;
      end else if (i.inverter_temp < c.inverter_temp_low &&
                   i.motor_temp < c.motor_temp_low && i.cooling_request[7]) begin
        r.pump = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

>>> src/evpsc_step.sv
// Combinational per-tick update: next controller state and the result beat.
module evpsc_step (
  input  evpsc_pkg::evpsc_state_t st,
  input  evpsc_pkg::evpsc_cfg_t   cfg,
  input  evpsc_pkg::evpsc_in_t    item,
  output evpsc_pkg::evpsc_state_t st_nxt,
  output evpsc_pkg::evpsc_res_t   res
);

  evpsc_pkg::evpsc_state_t s;
  logic                    sleep_req;

  always_comb begin
    s         = st;
    sleep_req = 1'b0;
    if (s.mode_timer != '1) begin
      s.mode_timer = s.mode_timer + evpsc_pkg::TIMER_BITS'(1);
    end
    if (item.unlock_event) begin
      s.unlock_sticky = 1'b1;
    end
    unique case (s.mode)
      evpsc_pkg::MODE_RUN: begin
        if (!item.ignition) begin
          s = evpsc_pkg::st_to_standby(s);
        end else begin
          s            = evpsc_pkg::st_cooling(s, cfg, item);
          s            = evpsc_pkg::st_arm_battery(s, cfg, item.battery_volts, item.bus_volts);
          s.wake_motor = 1'b1;
          s.wake_dcdc  = 1'b1;
          s.reverse    = item.reverse_gear;
        end
      end
      evpsc_pkg::MODE_CHARGING: begin
        s.wake_charger = 1'b1;
        s.wake_dcdc    = 1'b1;
        if (s.unlock_sticky) begin
          if (item.plug_locked) begin
            s.unlock_req      = 1'b1;
            s.charge_finished = 1'b1;
          end else begin
            s.unlock_sticky = 1'b0;
            s.demand        = evpsc_pkg::DEM_STANDBY;
            s               = evpsc_pkg::st_to_standby(s);
          end
        end
        s = evpsc_pkg::st_cooling(s, cfg, item);
        if (s.mode == evpsc_pkg::MODE_CHARGING) begin
          case (item.charger_status)
            evpsc_pkg::CST_SLEEP: begin
              s.led    = evpsc_pkg::LED_OFF;
              s.demand = evpsc_pkg::DEM_STANDBY;
            end
            evpsc_pkg::CST_STANDBY: begin
              s.led = evpsc_pkg::LED_STANDBY;
              if (s.charge_finished) begin
                s.demand         = evpsc_pkg::DEM_SLEEP;
                s                = evpsc_pkg::st_to_standby(s);
                s.unlock_req     = 1'b1;
                s.unlock_pending = 1'b1;
              end
            end
            evpsc_pkg::CST_READY: begin
              s.led = evpsc_pkg::LED_READY;
              if (s.unlock_pending || s.unlock_req) begin
                s.demand = evpsc_pkg::DEM_STANDBY;
              end else if (s.precharge_done) begin
                s.demand = evpsc_pkg::DEM_CHARGE;
              end
              s = evpsc_pkg::st_arm_battery(s, cfg, item.battery_volts, item.bus_volts);
            end
            evpsc_pkg::CST_CHARGING: begin
              s.led = evpsc_pkg::LED_CHARGING;
              s     = evpsc_pkg::st_arm_battery(s, cfg, item.battery_volts, item.bus_volts);
            end
            default: begin
              s = evpsc_pkg::st_disarm(s);
            end
          endcase
          if (s.unlock_pending) begin
            s.unlock_req = 1'b1;
            if (!item.plug_locked) begin
              s.demand = evpsc_pkg::DEM_STANDBY;
              s        = evpsc_pkg::st_to_standby(s);
              s.led    = evpsc_pkg::LED_OFF;
            end
          end
        end else begin
          s              = evpsc_pkg::st_disarm(s);
          s.wake_charger = 1'b0;
        end
      end
      default: begin
        s.wake_motor   = 1'b0;
        s.wake_dcdc    = 1'b0;
        s.wake_charger = 1'b0;
        s              = evpsc_pkg::st_disarm(s);
        if (item.charger_wake) begin
          s.mode = evpsc_pkg::MODE_CHARGING;
        end
        if (item.ignition) begin
          s.mode            = evpsc_pkg::MODE_RUN;
          s.charge_finished = 1'b0;
        end
        sleep_req = !item.ignition && !item.charger_wake;
      end
    endcase
    st_nxt = s;
  end

  always_comb begin
    res.vehicle_mode     = s.mode;
    res.wake_lines       = {s.wake_charger, s.wake_dcdc, s.wake_motor};
    res.contactor_closed = s.contactor;
    res.pump_on          = s.pump;
    res.reverse_light    = s.reverse;
    res.dcdc_enable      = s.dcdc_en;
    res.dcdc_boost       = (s.dcdc_mode == evpsc_pkg::DC_BOOST);
    res.charger_demand   = s.demand;
    res.charge_led       = s.led;
    res.unlock_request   = s.unlock_req;
    res.sleep_request    = sleep_req;
  end

endmodule

>>> src/ev_power_state_controller.sv
// Top level: configuration registers, controller state and the output beat register.
//
//   channel  direction  width  contents
//   in_*     slave      56     one tick of vehicle inputs per beat
//   out_*    master     24     one result beat per input beat
//   cfg_*    write      16     register index 0..7, no read-back
//
// One beat is taken per cycle while in_tready is high; its result appears in the
// output register on the next cycle. in_tready is high whenever the output register
// is empty or being drained, so an output stall holds the input in the same cycle.
// Synchronous active-low reset restores controller state and register defaults.
module ev_power_state_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // ignition, charger_wake, battery_volts[9:0], bus_volts[9:0], inverter_temp[7:0],
  // motor_temp[7:0], cooling_request[7:0], reverse_gear, charger_status[2:0],
  // plug_locked, unlock_event, zero pad
  input  logic [evpsc_pkg::IN_W-1:0]         in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // vehicle_mode[1:0], wake_lines[2:0], contactor_closed, pump_on, reverse_light,
  // dcdc_enable, dcdc_boost, charger_demand[1:0], charge_led[2:0], unlock_request,
  // sleep_request, zero pad
  output logic [evpsc_pkg::OUT_W-1:0]        out_tdata,
  input  logic                               cfg_we,
  input  logic [evpsc_pkg::CFG_IW-1:0]       cfg_index,
  input  logic [evpsc_pkg::CFG_DW-1:0]       cfg_wdata
);

  evpsc_pkg::evpsc_cfg_t   cfg_r;
  evpsc_pkg::evpsc_cfg_t   cfg_nxt;
  evpsc_pkg::evpsc_state_t st_r;
  evpsc_pkg::evpsc_state_t st_nxt;
  evpsc_pkg::evpsc_in_t    item;
  evpsc_pkg::evpsc_res_t   res;
  logic                    out_tvalid_r;
  logic                    out_tvalid_nxt;
  logic [evpsc_pkg::OUT_W-1:0] out_tdata_r;
  logic                    in_beat;

  assign item.ignition        = in_tdata[0];
  assign item.charger_wake    = in_tdata[1];
  assign item.battery_volts   = in_tdata[11:2];
  assign item.bus_volts       = in_tdata[21:12];
  assign item.inverter_temp   = $signed(in_tdata[29:22]);
  assign item.motor_temp      = $signed(in_tdata[37:30]);
  assign item.cooling_request = $signed(in_tdata[45:38]);
  assign item.reverse_gear    = in_tdata[46];
  assign item.charger_status  = in_tdata[49:47];
  assign item.plug_locked     = in_tdata[50];
  assign item.unlock_event    = in_tdata[51];

  evpsc_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        evpsc_pkg::CFG_MODE_CHANGE_DELAY:    cfg_nxt.mode_change_delay   = cfg_wdata;
        evpsc_pkg::CFG_PRECHARGE_WINDOW:     cfg_nxt.precharge_window    = cfg_wdata[7:0];
        evpsc_pkg::CFG_PRECHARGE_MIN_VOLTS:  cfg_nxt.precharge_min_volts = cfg_wdata[9:0];
        evpsc_pkg::CFG_INVERTER_TEMP_HIGH:   cfg_nxt.inverter_temp_high  = $signed(cfg_wdata[7:0]);
        evpsc_pkg::CFG_INVERTER_TEMP_LOW:    cfg_nxt.inverter_temp_low   = $signed(cfg_wdata[7:0]);
        evpsc_pkg::CFG_MOTOR_TEMP_HIGH:      cfg_nxt.motor_temp_high     = $signed(cfg_wdata[7:0]);
        evpsc_pkg::CFG_MOTOR_TEMP_LOW:       cfg_nxt.motor_temp_low      = $signed(cfg_wdata[7:0]);
        evpsc_pkg::CFG_COOLING_REQUEST_HIGH: cfg_nxt.cooling_request_high = $signed(cfg_wdata[7:0]);
        default:                             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (in_beat) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= evpsc_pkg::CFG_RESET;
      st_r         <= evpsc_pkg::ST_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (in_beat) begin
        st_r <= st_nxt;
      end
    end
  end

  // hold the result until the downstream side takes the beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_tdata_r <= {7'd0, res.sleep_request, res.unlock_request, res.charge_led,
                      res.charger_demand, res.dcdc_boost, res.dcdc_enable, res.reverse_light,
                      res.pump_on, res.contactor_closed, res.wake_lines, res.vehicle_mode};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> src/evpsc_checker.sv
// Port-level checker for the EV power state controller, bound to the top level.
module evpsc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [evpsc_pkg::OUT_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[1] && out_tdata[0]))
    else $error("illegal vehicle mode");

  a_sleep_standby: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |->
      out_tdata[1:0] == evpsc_pkg::MODE_STANDBY && out_tdata[4:2] == 3'b000 && !out_tdata[5])
    else $error("sleep request outside quiet standby");

endmodule

bind ev_power_state_controller evpsc_checker u_evpsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> sim/ev_power_state_controller_tb.sv
// Testbench for the EV power state controller: vehicle input ticks in, per-tick drives checked.
module ev_power_state_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import evpsc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int N_FIELDS    = 11;

  localparam logic [2:0] CST_FAULT_A = 3'd4;
  localparam logic [2:0] CST_FAULT_B = 3'd5;
  localparam logic [2:0] CST_FAULT_C = 3'd6;
  localparam logic [2:0] CST_FAULT_D = 3'd7;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we     = 1'b0;
  logic [CFG_IW-1:0] cfg_index  = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  ev_power_state_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  string field_name [N_FIELDS] = '{"vehicle_mode", "wake_lines", "contactor_closed", "pump_on",
                                   "reverse_light", "dcdc_enable", "dcdc_boost", "charger_demand",
                                   "charge_led", "unlock_request", "sleep_request"};
  int    field_lsb  [N_FIELDS] = '{0, 2, 5, 6, 7, 8, 9, 10, 12, 15, 16};
  int    field_w    [N_FIELDS] = '{2, 3, 1, 1, 1, 1, 1, 2, 3, 1, 1};

  evpsc_in_t        tick_q[$];
  evpsc_in_t        cur_tick;
  logic [OUT_W-1:0] drive_q[$];
  bit               in_fire    = 1'b0;
  int               send_idle  = 0;
  int               recv_stall = 0;
  int               errors     = 0;
  int               out_beats  = 0;
  int               quiet      = 0;
  int               n_queued   = 0;

  evpsc_cfg_t            cfg_copy;
  evpsc_mode_t           c_mode;
  evpsc_dcdc_t           c_dcdc;
  evpsc_demand_t         c_demand;
  logic [TIMER_BITS-1:0] c_timer;
  logic [2:0]            c_led;
  logic c_armed, c_pre_done, c_chg_fin, c_unl_sticky, c_unl_pend, c_unl_req;
  logic c_wake_m, c_wake_d, c_wake_c, c_contactor, c_pump, c_reverse, c_dcdc_en;

  function automatic void c_disarm();
    c_armed     = 1'b0;
    c_dcdc_en   = 1'b0;
    c_pre_done  = 1'b0;
    c_contactor = 1'b0;
  endfunction

  function automatic void c_standby();
    c_mode    = MODE_STANDBY;
    c_chg_fin = 1'b0;
    c_disarm();
  endfunction

  function automatic void c_dcdc_mode(evpsc_dcdc_t m);
    if (c_dcdc != m) begin
      c_dcdc    = m;
      c_timer   = '0;
      c_dcdc_en = 1'b0;
    end
  endfunction

  function automatic void c_precharge(int batt, int bus);
    int win;
    int minv;
    win  = cfg_copy.precharge_window;
    minv = cfg_copy.precharge_min_volts;
    if (!c_pre_done) begin
      c_dcdc_mode(DC_BOOST);
      if (c_timer >= cfg_copy.mode_change_delay) begin
        c_dcdc_en = 1'b1;
        if (bus >= batt - win && bus <= batt + win && bus > minv) begin
          c_pre_done  = 1'b1;
          c_contactor = 1'b1;
          c_dcdc_en   = 1'b0;
        end
      end
    end else begin
      c_armed = 1'b1;
      c_dcdc_mode(DC_BUCK);
      if (c_timer >= cfg_copy.mode_change_delay) c_dcdc_en = 1'b1;
    end
  endfunction

  function automatic void c_cooling(evpsc_in_t t);
    if (c_armed) begin
      if ($signed(t.inverter_temp) > $signed(cfg_copy.inverter_temp_high) ||
          $signed(t.motor_temp) > $signed(cfg_copy.motor_temp_high) ||
          $signed(t.cooling_request) > $signed(cfg_copy.cooling_request_high)) begin
        c_pump = 1'b1;
      end else if ($signed(t.inverter_temp) < $signed(cfg_copy.inverter_temp_low) &&
                   $signed(t.motor_temp) < $signed(cfg_copy.motor_temp_low) &&
                   $signed(t.cooling_request) < 0) begin
        c_pump = 1'b0;
      end
    end
  endfunction

  function automatic logic [OUT_W-1:0] step_controller(evpsc_in_t t);
    logic sleep_req;
    int   batt;
    int   bus;
    sleep_req = 1'b0;
    batt      = t.battery_volts;
    bus       = t.bus_volts;
    if (c_timer != '1) c_timer = c_timer + 1'b1;
    if (t.unlock_event) c_unl_sticky = 1'b1;
    case (c_mode)
      MODE_RUN: begin
        if (!t.ignition) begin
          c_standby();
        end else begin
          c_cooling(t);
          c_precharge(batt, bus);
          c_wake_m  = 1'b1;
          c_wake_d  = 1'b1;
          c_reverse = t.reverse_gear;
        end
      end
      MODE_CHARGING: begin
        c_wake_c = 1'b1;
        c_wake_d = 1'b1;
        if (c_unl_sticky) begin
          if (t.plug_locked) begin
            c_unl_req = 1'b1;
            c_chg_fin = 1'b1;
          end else begin
            c_unl_sticky = 1'b0;
            c_demand     = DEM_STANDBY;
            c_standby();
          end
        end
        c_cooling(t);
        if (c_mode == MODE_CHARGING) begin
          case (t.charger_status)
            CST_SLEEP: begin
              c_led    = LED_OFF;
              c_demand = DEM_STANDBY;
            end
            CST_STANDBY: begin
              c_led = LED_STANDBY;
              if (c_chg_fin) begin
                c_demand = DEM_SLEEP;
                c_standby();
                c_unl_req  = 1'b1;
                c_unl_pend = 1'b1;
              end
            end
            CST_READY: begin
              c_led = LED_READY;
              if (c_unl_pend || c_unl_req) c_demand = DEM_STANDBY;
              else if (c_pre_done) c_demand = DEM_CHARGE;
              c_precharge(batt, bus);
            end
            CST_CHARGING: begin
              c_led = LED_CHARGING;
              c_precharge(batt, bus);
            end
            default: c_disarm();
          endcase
          if (c_unl_pend) begin
            c_unl_req = 1'b1;
            if (!t.plug_locked) begin
              c_demand = DEM_STANDBY;
              c_standby();
              c_led = LED_OFF;
            end
          end
        end else begin
          c_disarm();
          c_wake_c = 1'b0;
        end
      end
      default: begin
        c_wake_m = 1'b0;
        c_wake_d = 1'b0;
        c_wake_c = 1'b0;
        c_disarm();
        if (t.charger_wake) c_mode = MODE_CHARGING;
        if (t.ignition) begin
          c_mode    = MODE_RUN;
          c_chg_fin = 1'b0;
        end
        if (!t.ignition && !t.charger_wake) sleep_req = 1'b1;
      end
    endcase
    return {7'b0, sleep_req, c_unl_req, c_led, c_demand, c_dcdc == DC_BOOST, c_dcdc_en,
            c_reverse, c_pump, c_contactor, c_wake_c, c_wake_d, c_wake_m, c_mode};
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  function automatic logic signed [7:0] rand_temp();
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return 8'($urandom_range(90));
  endfunction

  function automatic evpsc_in_t make_tick(bit ign, bit cw, logic [2:0] cst, bit lk, bit unl);
    evpsc_in_t t;
    int        win;
    int        v;
    t.ignition        = ign;
    t.charger_wake    = cw;
    t.battery_volts   = 10'($urandom_range(1023));
    t.inverter_temp   = rand_temp();
    t.motor_temp      = rand_temp();
    t.cooling_request = rand_temp();
    t.reverse_gear    = 1'($urandom_range(1));
    t.charger_status  = cst;
    t.plug_locked     = lk;
    t.unlock_event    = unl;
    if ($urandom_range(99) < 85) begin
      win = cfg_copy.precharge_window;
      v   = int'($urandom_range(2 * win + 4)) - win - 2 + int'(t.battery_volts);
      t.bus_volts = (v < 0) ? 10'd0 : (v > 1023) ? 10'd1023 : 10'(v);
    end else begin
      t.bus_volts = 10'($urandom_range(1023));
    end
    return t;
  endfunction

  task automatic push_tick(evpsc_in_t t);
    tick_q.push_back(t);
    n_queued++;
  endtask

  task automatic push_fixed(bit ign, bit cw, int batt, int bus, int inv, int mot, int req,
                            bit rev, logic [2:0] cst, bit lk, bit unl);
    evpsc_in_t t;
    t.ignition        = ign;
    t.charger_wake    = cw;
    t.battery_volts   = 10'(batt);
    t.bus_volts       = 10'(bus);
    t.inverter_temp   = 8'(inv);
    t.motor_temp      = 8'(mot);
    t.cooling_request = 8'(req);
    t.reverse_gear    = rev;
    t.charger_status  = cst;
    t.plug_locked     = lk;
    t.unlock_event    = unl;
    push_tick(t);
  endtask

  task automatic queue_drive(int n);
    push_tick(make_tick(1'b1, 1'($urandom_range(1)), 3'($urandom_range(7)), 1'b1, 1'b0));
    repeat (n) begin
      push_tick(make_tick(1'b1, 1'($urandom_range(1)), 3'($urandom_range(7)),
                          1'($urandom_range(1)), 1'b0));
    end
    push_tick(make_tick(1'b0, $urandom_range(3) == 0, 3'($urandom_range(7)), 1'b1, 1'b0));
  endtask

  task automatic queue_charge(int n, bit rough);
    int         r;
    logic [2:0] cst;
    bit         lk;
    bit         unl;
    push_tick(make_tick(1'b0, 1'b1, CST_STANDBY, 1'b1, 1'b0));
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 10) cst = CST_SLEEP;
      else if (r < 20) cst = CST_STANDBY;
      else if (r < 55) cst = CST_READY;
      else if (r < 90) cst = CST_CHARGING;
      else cst = 3'(CST_FAULT_A + $urandom_range(3));
      lk  = rough ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
      unl = rough && ($urandom_range(14) == 0);
      push_tick(make_tick(1'($urandom_range(1)), 1'($urandom_range(1)), cst, lk, unl));
    end
    // leave charging through an unlock with the plug free
    push_tick(make_tick(1'b0, 1'b0, 3'($urandom_range(7)), 1'b0, 1'b1));
  endtask

  task automatic queue_mix(int n, bit rough);
    int goal;
    goal = n_queued + n;
    while (n_queued < goal) begin
      case ($urandom_range(9))
        0, 1, 2, 3: queue_drive($urandom_range(24, 4));
        4, 5, 6, 7: queue_charge($urandom_range(24, 4), rough);
        default: begin
          repeat ($urandom_range(3, 1)) begin
            push_tick(make_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                                3'($urandom_range(7)), 1'($urandom_range(1)),
                                rough && ($urandom_range(7) == 0)));
          end
        end
      endcase
    end
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE_CHANGE_DELAY:    cfg_copy.mode_change_delay    = val;
      CFG_PRECHARGE_WINDOW:     cfg_copy.precharge_window     = val[7:0];
      CFG_PRECHARGE_MIN_VOLTS:  cfg_copy.precharge_min_volts  = val[9:0];
      CFG_INVERTER_TEMP_HIGH:   cfg_copy.inverter_temp_high   = val[7:0];
      CFG_INVERTER_TEMP_LOW:    cfg_copy.inverter_temp_low    = val[7:0];
      CFG_MOTOR_TEMP_HIGH:      cfg_copy.motor_temp_high      = val[7:0];
      CFG_MOTOR_TEMP_LOW:       cfg_copy.motor_temp_low       = val[7:0];
      CFG_COOLING_REQUEST_HIGH: cfg_copy.cooling_request_high = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int delay, int win, int minv, int ih, int il, int mh, int ml,
                            int ch);
    cfg_write(CFG_MODE_CHANGE_DELAY, 16'(delay));
    cfg_write(CFG_PRECHARGE_WINDOW, 16'(win));
    cfg_write(CFG_PRECHARGE_MIN_VOLTS, 16'(minv));
    cfg_write(CFG_INVERTER_TEMP_HIGH, {8'h00, 8'(ih)});
    cfg_write(CFG_INVERTER_TEMP_LOW, {8'h00, 8'(il)});
    cfg_write(CFG_MOTOR_TEMP_HIGH, {8'h00, 8'(mh)});
    cfg_write(CFG_MOTOR_TEMP_LOW, {8'h00, 8'(ml)});
    cfg_write(CFG_COOLING_REQUEST_HIGH, {8'h00, 8'(ch)});
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (tick_q.size() != 0 || in_tvalid || drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    evpsc_in_t t;
    out_tready <= ($urandom_range(99) >= recv_stall);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        t = tick_q.pop_front();
        cur_tick  <= t;
        in_tdata  <= {4'b0, t.unlock_event, t.plug_locked, t.charger_status, t.reverse_gear,
                      t.cooling_request, t.motor_temp, t.inverter_temp, t.bus_volts,
                      t.battery_volts, t.charger_wake, t.ignition};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    logic [OUT_W-1:0] mask;
    int               k;
    in_fire = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_beats++;
        if (drive_q.size() == 0) begin
          note_error($sformatf("beat %0d: unexpected result %h", out_beats, out_tdata));
        end else begin
          want = drive_q.pop_front();
          for (k = 0; k < N_FIELDS; k++) begin
            mask = ((OUT_W'(1) << field_w[k]) - 1'b1) << field_lsb[k];
            if ((want & mask) !== (out_tdata & mask)) begin
              note_error($sformatf("beat %0d: %s expected %0d got %0d", out_beats,
                                   field_name[k], (want & mask) >> field_lsb[k],
                                   (out_tdata & mask) >> field_lsb[k]));
            end
          end
        end
      end
      if (in_fire) drive_q.push_back(step_controller(cur_tick));
      if (in_fire || (out_tvalid && out_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cfg_copy     = CFG_RESET;
    c_mode       = MODE_STANDBY;
    c_dcdc       = DC_UNSET;
    c_demand     = DEM_STANDBY;
    c_timer      = '0;
    c_led        = LED_OFF;
    c_armed      = 1'b0;
    c_pre_done   = 1'b0;
    c_chg_fin    = 1'b0;
    c_unl_sticky = 1'b0;
    c_unl_pend   = 1'b0;
    c_unl_req    = 1'b0;
    c_wake_m     = 1'b0;
    c_wake_d     = 1'b0;
    c_wake_c     = 1'b0;
    c_contactor  = 1'b0;
    c_pump       = 1'b0;
    c_reverse    = 1'b0;
    c_dcdc_en    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    set_config(1, 20, 50, 60, 50, 80, 70, 50);
    push_fixed(0, 0, 0, 0, 0, 0, 0, 0, CST_SLEEP, 0, 0);
    push_fixed(1, 1, 400, 405, 0, 0, -1, 0, CST_SLEEP, 0, 0);
    push_fixed(1, 0, 400, 405, 20, 20, -10, 0, CST_CHARGING, 1, 0);
    push_fixed(1, 0, 400, 395, 20, 20, -10, 0, CST_CHARGING, 1, 0);
    push_fixed(1, 0, 400, 400, 20, 20, -10, 0, CST_CHARGING, 1, 0);
    push_fixed(1, 0, 400, 400, 127, 20, -10, 0, CST_CHARGING, 1, 0);
    push_fixed(1, 0, 400, 400, 20, 127, -10, 1, CST_CHARGING, 1, 0);
    push_fixed(1, 0, 400, 400, -128, -128, -128, 1, CST_CHARGING, 1, 0);
    push_fixed(1, 0, 1023, 0, 20, 20, 127, 0, CST_CHARGING, 1, 0);
    push_fixed(0, 0, 400, 400, 20, 20, -10, 0, CST_SLEEP, 1, 0);
    push_fixed(0, 1, 1023, 1023, 20, 20, -10, 0, CST_READY, 1, 0);
    repeat (3) push_fixed(0, 1, 1023, 1023, 20, 20, -10, 0, CST_READY, 1, 0);
    push_fixed(0, 1, 1023, 1023, 70, 20, -10, 0, CST_CHARGING, 1, 0);
    push_fixed(0, 0, 1023, 1023, 20, 20, -10, 0, CST_FAULT_A, 1, 0);
    push_fixed(0, 0, 1023, 1023, 20, 20, -10, 0, CST_SLEEP, 1, 0);
    push_fixed(0, 0, 1023, 1023, 20, 20, -10, 0, CST_STANDBY, 1, 0);
    push_fixed(0, 0, 1023, 1023, 20, 20, -10, 0, CST_FAULT_C, 1, 0);
    push_fixed(1, 0, 0, 0, 20, 20, -10, 0, CST_CHARGING, 1, 0);
    push_fixed(0, 0, 0, 0, 20, 20, -10, 0, CST_FAULT_B, 0, 0);
    push_fixed(0, 0, 500, 500, 20, 20, -10, 0, CST_FAULT_D, 0, 1);
    push_fixed(0, 0, 500, 500, 20, 20, -10, 0, CST_SLEEP, 0, 0);
    wait_idle();

    set_config(0, 0, 0, 127, -128, 127, -128, 127);
    queue_mix(110, 1'b0);
    wait_idle();

    set_config(3, 255, 0, -128, 127, -128, 127, -128);
    send_idle = 74;
    queue_mix(110, 1'b0);
    wait_idle();

    set_config(4, 40, 100, 30, 10, 40, 20, 0);
    send_idle  = 0;
    recv_stall = 74;
    queue_mix(50, 1'b0);
    // hold the sender until the pipe is empty
    wait_idle();
    queue_mix(50, 1'b0);
    wait_idle();

    set_config(65535, 128, 1023, 0, 0, 0, 0, 0);
    recv_stall = 0;
    queue_mix(40, 1'b0);
    wait_idle();

    set_config(2, 20, 50, 60, 50, 80, 70, 50);
    send_idle  = 6;
    recv_stall = 6;
    queue_mix(120, 1'b1);
    wait_idle();

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
